[rtl/core/http_chunked_body_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication
`define HCBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  localparam int SizeBitsDefault = 32;
  localparam int CmdDepth        = 4;
  localparam int ResDepth        = 4;

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowF = 8'h66;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpF  = 8'h46;
  localparam logic [3:0] HexTen   = 4'hA;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef enum logic [8:0] {
    PH_SIZE    = 9'b000000001,
    PH_SIZE_LF = 9'b000000010,
    PH_EXT     = 9'b000000100,
    PH_EXT_CR  = 9'b000001000,
    PH_DATA    = 9'b000010000,
    PH_DATA_CR = 9'b000100000,
    PH_DATA_LF = 9'b001000000,
    PH_DONE    = 9'b010000000,
    PH_ERR     = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       last;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/hcbd_fifo.sv]
// ----------------------------------------------------------------------------
// hcbd_fifo
// Small first-word-fall-through queue built from registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_defines.svh"

module hcbd_fifo #(
  parameter int Width = 8,
  parameter int Depth = hcbd_pkg::CmdDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [Width-1:0] rdata_o
);
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = AddrW + 1;

  logic [Width-1:0] entries_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + CntW'(1);
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  `HCBD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(Depth), "queue count above depth")
  `HCBD_ASSERT_NEXT(a_count_up, push_ok && !pop_ok, count_q == $past(count_q) + CntW'(1),
                    "queue count did not advance on push")
  `HCBD_ASSERT_NEXT(a_rd_move, pop_ok, rd_ptr_q != $past(rd_ptr_q) || Depth == 1,
                    "read pointer held on pop")

endmodule

`default_nettype wire

[rtl/core/hcbd_front.sv]
// ----------------------------------------------------------------------------
// hcbd_front
// Classify each incoming byte and queue it for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_front #(
  parameter int Depth = hcbd_pkg::CmdDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          body_end_i,
  output logic               cmd_valid_o,
  output hcbd_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);
  import hcbd_pkg::*;

  cmd_t                 cls;
  logic [7:0]           diff;
  logic [$bits(cmd_t)-1:0] rdata;
  logic                 empty;

  always_comb begin
    cls         = '0;
    cls.data    = in_byte_i;
    cls.last    = body_end_i;
    cls.is_cr   = (in_byte_i == CharCr);
    cls.is_lf   = (in_byte_i == CharLf);
    cls.is_semi = (in_byte_i == CharSemi);
    diff        = '0;
    if (in_byte_i inside {[CharZero:CharNine]}) begin
      diff        = in_byte_i - CharZero;
      cls.is_hex  = 1'b1;
      cls.hex_val = diff[3:0];
    end else if (in_byte_i inside {[CharLowA:CharLowF]}) begin
      diff        = in_byte_i - CharLowA;
      cls.is_hex  = 1'b1;
      cls.hex_val = diff[3:0] + HexTen;
    end else if (in_byte_i inside {[CharUpA:CharUpF]}) begin
      diff        = in_byte_i - CharUpA;
      cls.is_hex  = 1'b1;
      cls.hex_val = diff[3:0] + HexTen;
    end
  end

  hcbd_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (Depth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .empty_o (empty),
    .rdata_o (rdata)
  );

  assign cmd_valid_o = !empty;
  assign cmd_o       = cmd_t'(rdata);

endmodule

`default_nettype wire

[rtl/core/hcbd_back.sv]
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk framing state machine: size parse, data pass-through, CRLF checks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_defines.svh"

module hcbd_back #(
  parameter int SizeBits = hcbd_pkg::SizeBitsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  hcbd_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  output logic                 res_push_o,
  output hcbd_pkg::res_t       res_o,
  input  wire logic            res_full_i
);
  import hcbd_pkg::*;

  phase_e               phase_q, phase_d;
  logic [SizeBits-1:0]  bytes_q, bytes_d;
  logic                 take;
  logic                 have;
  kind_e                kind;
  logic [7:0]           rbyte;
  logic                 emit;
  logic                 finished;
  logic                 decided;

  assign take      = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = take;

  always_comb begin
    phase_d  = phase_q;
    bytes_d  = bytes_q;
    have     = 1'b0;
    kind     = KIND_BAD;
    rbyte    = '0;
    emit     = 1'b0;
    finished = 1'b0;
    decided  = 1'b0;
    case (phase_q)
      PH_SIZE: begin
        if (cmd_i.is_hex) begin
          if (bytes_q[SizeBits-1 -: 4] != '0) begin
            phase_d = PH_ERR;
            have    = 1'b1;
          end else begin
            bytes_d = {bytes_q[SizeBits-5:0], cmd_i.hex_val};
          end
        end else if (cmd_i.is_semi) begin
          phase_d = PH_EXT;
        end else if (cmd_i.is_cr) begin
          phase_d = PH_SIZE_LF;
        end else begin
          phase_d = PH_ERR;
          have    = 1'b1;
        end
      end
      PH_EXT: begin
        if (cmd_i.is_cr) begin
          phase_d = PH_EXT_CR;
        end
      end
      PH_SIZE_LF, PH_EXT_CR: begin
        if (cmd_i.is_lf) begin
          if (bytes_q == '0) begin
            phase_d = PH_DONE;
            kind    = KIND_OK;
            have    = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end else if (phase_q == PH_EXT_CR) begin
          if (!cmd_i.is_cr) begin
            phase_d = PH_EXT;
          end
        end else begin
          phase_d = PH_ERR;
          have    = 1'b1;
        end
      end
      PH_DATA: begin
        kind    = KIND_DATA;
        rbyte   = cmd_i.data;
        have    = 1'b1;
        bytes_d = bytes_q - SizeBits'(1);
        if (bytes_q == SizeBits'(1)) begin
          phase_d = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (cmd_i.is_cr) begin
          phase_d = PH_DATA_LF;
        end else begin
          phase_d = PH_ERR;
          have    = 1'b1;
        end
      end
      PH_DATA_LF: begin
        if (cmd_i.is_lf) begin
          phase_d = PH_SIZE;
          bytes_d = '0;
        end else begin
          phase_d = PH_ERR;
          have    = 1'b1;
        end
      end
      PH_DONE, PH_ERR: begin
      end
      default: begin
        phase_d = PH_ERR;
      end
    endcase

    emit = have;
    if (cmd_i.last) begin
      finished = (phase_d == PH_DONE) || (phase_d == PH_ERR);
      decided  = have && (kind != KIND_DATA);
      phase_d  = PH_SIZE;
      bytes_d  = '0;
      rbyte    = '0;
      if (!decided) begin
        kind = KIND_BAD;
      end
      emit = decided || !finished;
    end
  end

  assign res_push_o = take && emit;
  assign res_o.kind = kind;
  assign res_o.data = rbyte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      bytes_q <= '0;
    end else if (take) begin
      phase_q <= phase_d;
      bytes_q <= bytes_d;
    end
  end

  `HCBD_ASSERT_IMP(a_data_count, phase_q == PH_DATA, bytes_q != '0,
                   "data phase with zero bytes left")
  `HCBD_ASSERT_IMP(a_no_overrun, res_push_o, !res_full_i, "result pushed into full queue")
  `HCBD_ASSERT_IMP(a_data_src, res_push_o && res_o.kind == KIND_DATA,
                   phase_q == PH_DATA && !cmd_i.last, "data result outside data phase")
  `HCBD_ASSERT_NEXT(a_end_reset, take && cmd_i.last, phase_q == PH_SIZE && bytes_q == '0,
                    "parser not reset after final byte")

endmodule

`default_nettype wire

[rtl/core/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body byte by byte into payload bytes and a
// final ok or malformed verdict.
// ----------------------------------------------------------------------------
// Throughput is one body byte per clock cycle, sustained as long as pop keeps
// up; the framing state machine and its size counter (a 4-bit shift-in while
// parsing sizes, a decrement while passing data) update once per taken byte.
// With both queues empty, an accepted byte is registered in the command queue,
// read by the state machine and its result registered in the result queue.
// Both sides are queues of four transactions, so push may run ahead of the
// parser and the parser ahead of pop. Each byte gives at most one result: a
// data byte, one ok after a zero or empty size line, or one malformed verdict;
// the byte marked body_end returns the parser to its reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
  parameter int SizeBits = hcbd_pkg::SizeBitsDefault,
  parameter int CmdDepth = hcbd_pkg::CmdDepth,
  parameter int ResDepth = hcbd_pkg::ResDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       body_end_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      data_byte_o
);
  import hcbd_pkg::*;

  logic                    cmd_valid;
  cmd_t                    cmd;
  logic                    cmd_pop;
  logic                    res_push;
  res_t                    res;
  logic                    res_full;
  logic [$bits(res_t)-1:0] res_rdata;
  res_t                    res_head;

  hcbd_front #(
    .Depth (CmdDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .body_end_i  (body_end_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  hcbd_back #(
    .SizeBits (SizeBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  hcbd_fifo #(
    .Width ($bits(res_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_rdata)
  );

  assign res_head    = res_t'(res_rdata);
  assign out_kind_o  = res_head.kind;
  assign data_byte_o = res_head.data;

endmodule

`default_nettype wire
